// ===== src/sci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment circle intersect package
// Shared widths, register reset value and pipeline constants.
// ----------------------------------------------------------------------------
package sci_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int T_FRAC_BITS_DEF = 16;

	localparam int MIN_MOVE_W = 21;
	localparam logic [MIN_MOVE_W-1:0] MIN_MOVE_RESET = 21'd4295;

	// Register stages through one split multiplier.
	localparam int MUL_LAT = 4;

endpackage

// ===== src/sci_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment circle intersect channels
// Segment request, configuration write and result channels.
// ----------------------------------------------------------------------------
interface sci_seg_if import sci_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_z;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_z;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_z;
	logic        [COORD_WIDTH-2:0] radius;

	modport source (output valid, start_x, start_z, end_x, end_z, center_x, center_z, radius,
		input ready);
	modport sink (input valid, start_x, start_z, end_x, end_z, center_x, center_z, radius,
		output ready);
endinterface

interface sci_cfg_if import sci_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [MIN_MOVE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface sci_res_if import sci_pkg::*; #(
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [T_FRAC_BITS:0] hit_time;

	modport source (output valid, hit, hit_time, input ready);
	modport sink (input valid, hit, hit_time, output ready);
endinterface

// ===== src/segment_circle_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment circle intersect
// Streaming 2D segment against circle hit test with exact entry or exit time.
// ----------------------------------------------------------------------------
// The seg channel takes one beat per segment and circle pair; the res channel
// returns one beat per pair with the hit flag and the hit time in unsigned
// Q1.T_FRAC_BITS, zero when there is no hit. The cfg channel writes the
// minimum squared move length and is always ready; write it only while the
// pipeline is empty.
// Throughput is one pair per cycle unless a result beat waits on a low res.ready.
// The depth is set by the bit-per-stage square root of the discriminant and
// the bit-per-stage division by the squared length that follows it.
// The whole pipeline advances together: while a result beat waits on a low
// res.ready, seg.ready is low and every stage holds, so nothing is lost or
// repeated. Reset clears all valid bits and loads the register default.
// ----------------------------------------------------------------------------
module segment_circle_intersect import sci_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	sci_seg_if.sink   seg,
	sci_cfg_if.sink   cfg,
	sci_res_if.source res
);
	localparam int CW = COORD_WIDTH;
	localparam int TF = T_FRAC_BITS;
	localparam int EW = CW + 1;
	localparam int PW = 2 * CW + 4;
	localparam int DW = 2 * PW;
	localparam int RW = DW + 2 * TF;
	localparam int QW = RW / 2;
	localparam int NW = PW + TF + 2;

	logic en;
	logic [MIN_MOVE_W-1:0] min_move_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_move_q <= MIN_MOVE_RESET;
		end else if (cfg.valid) begin
			min_move_q <= cfg.data;
		end
	end

	// Differences.
	logic v_s1;
	logic signed [EW-1:0] dx_s1, dz_s1, fx_s1, fz_s1, rr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= EW'(seg.end_x) - EW'(seg.start_x);
			dz_s1 <= EW'(seg.end_z) - EW'(seg.start_z);
			fx_s1 <= EW'(seg.start_x) - EW'(seg.center_x);
			fz_s1 <= EW'(seg.start_z) - EW'(seg.center_z);
			rr_s1 <= {2'b00, seg.radius};
		end
	end

	// Coordinate products.
	logic signed [2*EW-1:0] p_dxdx, p_dzdz, p_fxdx, p_fzdz, p_fxfx, p_fzfz, p_rr;

	sci_mul #(.W(EW)) u_mul_dxdx (.clk(clk), .en(en), .a(dx_s1), .b(dx_s1), .p(p_dxdx));
	sci_mul #(.W(EW)) u_mul_dzdz (.clk(clk), .en(en), .a(dz_s1), .b(dz_s1), .p(p_dzdz));
	sci_mul #(.W(EW)) u_mul_fxdx (.clk(clk), .en(en), .a(fx_s1), .b(dx_s1), .p(p_fxdx));
	sci_mul #(.W(EW)) u_mul_fzdz (.clk(clk), .en(en), .a(fz_s1), .b(dz_s1), .p(p_fzdz));
	sci_mul #(.W(EW)) u_mul_fxfx (.clk(clk), .en(en), .a(fx_s1), .b(fx_s1), .p(p_fxfx));
	sci_mul #(.W(EW)) u_mul_fzfz (.clk(clk), .en(en), .a(fz_s1), .b(fz_s1), .p(p_fzfz));
	sci_mul #(.W(EW)) u_mul_rr   (.clk(clk), .en(en), .a(rr_s1), .b(rr_s1), .p(p_rr));

	logic vm1_q [MUL_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MUL_LAT; i++) vm1_q[i] <= 1'b0;
		end else if (en) begin
			vm1_q[0] <= v_s1;
			for (int i = 1; i < MUL_LAT; i++) vm1_q[i] <= vm1_q[i-1];
		end
	end

	// Quadratic coefficients, with y = a + b.
	logic v_s6;
	logic signed [PW-1:0] a_s6, b_s6, c_s6, y_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= vm1_q[MUL_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s6 <= PW'(p_dxdx) + PW'(p_dzdz);
			b_s6 <= PW'(p_fxdx) + PW'(p_fzdz);
			c_s6 <= PW'(p_fxfx) + PW'(p_fzfz) - PW'(p_rr);
			y_s6 <= PW'(p_dxdx) + PW'(p_dzdz) + PW'(p_fxdx) + PW'(p_fzdz);
		end
	end

	// Coefficient products.
	logic signed [DW-1:0] p_bb, p_ac, p_yy;

	sci_mul #(.W(PW)) u_mul_bb (.clk(clk), .en(en), .a(b_s6), .b(b_s6), .p(p_bb));
	sci_mul #(.W(PW)) u_mul_ac (.clk(clk), .en(en), .a(a_s6), .b(c_s6), .p(p_ac));
	sci_mul #(.W(PW)) u_mul_yy (.clk(clk), .en(en), .a(y_s6), .b(y_s6), .p(p_yy));

	logic                 vm2_q [MUL_LAT];
	logic signed [PW-1:0] am2_q [MUL_LAT];
	logic signed [PW-1:0] bm2_q [MUL_LAT];
	logic signed [PW-1:0] cm2_q [MUL_LAT];
	logic signed [PW-1:0] ym2_q [MUL_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MUL_LAT; i++) vm2_q[i] <= 1'b0;
		end else if (en) begin
			vm2_q[0] <= v_s6;
			for (int i = 1; i < MUL_LAT; i++) vm2_q[i] <= vm2_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am2_q[0] <= a_s6;
			bm2_q[0] <= b_s6;
			cm2_q[0] <= c_s6;
			ym2_q[0] <= y_s6;
			for (int i = 1; i < MUL_LAT; i++) begin
				am2_q[i] <= am2_q[i-1];
				bm2_q[i] <= bm2_q[i-1];
				cm2_q[i] <= cm2_q[i-1];
				ym2_q[i] <= ym2_q[i-1];
			end
		end
	end

	// Discriminant.
	logic v_s11;
	logic signed [PW-1:0] a_s11, b_s11, c_s11, y_s11;
	logic signed [DW-1:0] d_s11, ysq_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= vm2_q[MUL_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s11   <= p_bb - p_ac;
			ysq_s11 <= p_yy;
			a_s11   <= am2_q[MUL_LAT-1];
			b_s11   <= bm2_q[MUL_LAT-1];
			c_s11   <= cm2_q[MUL_LAT-1];
			y_s11   <= ym2_q[MUL_LAT-1];
		end
	end

	// Root selection.
	logic a_zero, a_small, d_neg, b_le0, c_ge0, c_le0, y_ge0, e_ok, x_ok;

	always_comb begin
		a_zero  = a_s11 == '0;
		a_small = $unsigned(a_s11) < PW'(min_move_q);
		d_neg   = d_s11[DW-1];
		b_le0   = b_s11[PW-1] || (b_s11 == '0);
		c_ge0   = !c_s11[PW-1];
		c_le0   = c_s11[PW-1] || (c_s11 == '0);
		y_ge0   = !y_s11[PW-1];
		e_ok    = c_ge0 && b_le0 && (y_ge0 || (ysq_s11 <= d_s11));
		x_ok    = (b_le0 || c_le0) && y_ge0 && (d_s11 <= ysq_s11);
	end

	logic v_s12, hit_s12, ent_s12;
	logic signed [PW-1:0] a_s12, b_s12;
	logic [RW-1:0] rad_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s12 <= !a_zero && !a_small && !d_neg && (e_ok || x_ok);
			ent_s12 <= e_ok;
			a_s12   <= a_s11;
			b_s12   <= b_s11;
			rad_s12 <= d_neg ? '0 : {d_s11, {(2*TF){1'b0}}};
		end
	end

	// Square root of the scaled discriminant.
	logic [QW-1:0] root;
	logic          exact;

	sci_sqrt #(.RW(RW)) u_sqrt (.clk(clk), .en(en), .rad(rad_s12), .root(root), .exact(exact));

	logic                 vq_q   [QW];
	logic                 hitq_q [QW];
	logic                 entq_q [QW];
	logic signed [PW-1:0] aq_q   [QW];
	logic signed [PW-1:0] bq_q   [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) vq_q[i] <= 1'b0;
		end else if (en) begin
			vq_q[0] <= v_s12;
			for (int i = 1; i < QW; i++) vq_q[i] <= vq_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hitq_q[0] <= hit_s12;
			entq_q[0] <= ent_s12;
			aq_q[0]   <= a_s12;
			bq_q[0]   <= b_s12;
			for (int i = 1; i < QW; i++) begin
				hitq_q[i] <= hitq_q[i-1];
				entq_q[i] <= entq_q[i-1];
				aq_q[i]   <= aq_q[i-1];
				bq_q[i]   <= bq_q[i-1];
			end
		end
	end

	// Numerator of the scaled root. The entry root uses the ceiling of the root.
	logic [NW-1:0] bs_ext, v_ext, u_ext;
	logic v_s13, hit_s13;
	logic [NW-1:0] n_s13, a_s13;

	always_comb begin
		bs_ext = NW'(signed'({bq_q[QW-1], {TF{1'b0}}}));
		v_ext  = {2'b00, root};
		u_ext  = v_ext + NW'(!exact);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s13 <= vq_q[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s13 <= hitq_q[QW-1];
			n_s13   <= entq_q[QW-1] ? (-bs_ext - u_ext) : (v_ext - bs_ext);
			a_s13   <= NW'($unsigned(aq_q[QW-1]));
		end
	end

	// Restoring division by the squared length, one quotient bit per stage.
	logic          v_s14   [TF+1];
	logic          hit_s14 [TF+1];
	logic [NW-1:0] rem_s14 [TF+1];
	logic [NW-1:0] a_s14   [TF+1];
	logic [TF:0]   q_s14   [TF+1];

	for (genvar j = 0; j <= TF; j++) begin : g_div
		logic          v_in, hit_in, ge;
		logic [NW-1:0] rem_in, a_in, trial;
		logic [TF:0]   q_in;

		if (j == 0) begin : g_first
			assign v_in   = v_s13;
			assign hit_in = hit_s13;
			assign rem_in = n_s13;
			assign a_in   = a_s13;
			assign q_in   = '0;
		end else begin : g_next
			assign v_in   = v_s14[j-1];
			assign hit_in = hit_s14[j-1];
			assign rem_in = rem_s14[j-1];
			assign a_in   = a_s14[j-1];
			assign q_in   = q_s14[j-1];
		end

		assign trial = a_in << (TF - j);
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s14[j] <= 1'b0;
			end else if (en) begin
				v_s14[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hit_s14[j] <= hit_in;
				rem_s14[j] <= ge ? rem_in - trial : rem_in;
				a_s14[j]   <= a_in;
				q_s14[j]   <= q_in | ((TF+1)'(ge) << (TF - j));
			end
		end
	end

	// Result register.
	logic        v_s15, hit_s15;
	logic [TF:0] time_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s15 <= v_s14[TF];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s15  <= hit_s14[TF];
			time_s15 <= hit_s14[TF] ? q_s14[TF] : '0;
		end
	end

	assign en           = !v_s15 || res.ready;
	assign seg.ready    = en;
	assign res.valid    = v_s15;
	assign res.hit      = hit_s15;
	assign res.hit_time = time_s15;
endmodule

// ===== src/sci_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment circle intersect multiplier
// Signed multiplier split into four half-width partial products, four stages.
// ----------------------------------------------------------------------------
module sci_mul import sci_pkg::*; #(
	parameter int W = 33
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	localparam int H = (W + 1) / 2;
	localparam int L = W - H;

	logic           neg_s1, neg_s2, neg_s3;
	logic [W-1:0]   ma_s1, mb_s1;
	logic [2*H-1:0] pp_ll_s2;
	logic [W-1:0]   pp_lh_s2, pp_hl_s2;
	logic [2*L-1:0] pp_hh_s2;
	logic [2*W-1:0] sum_s3;
	logic signed [2*W-1:0] p_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= a[W-1] ^ b[W-1];
			ma_s1    <= a[W-1] ? W'(-a) : W'(a);
			mb_s1    <= b[W-1] ? W'(-b) : W'(b);
			neg_s2   <= neg_s1;
			pp_ll_s2 <= ma_s1[H-1:0] * mb_s1[H-1:0];
			pp_lh_s2 <= ma_s1[H-1:0] * mb_s1[W-1:H];
			pp_hl_s2 <= ma_s1[W-1:H] * mb_s1[H-1:0];
			pp_hh_s2 <= ma_s1[W-1:H] * mb_s1[W-1:H];
			neg_s3   <= neg_s2;
			sum_s3   <= ((2*W)'(pp_hh_s2) << (2*H))
				+ (((2*W)'(pp_lh_s2) + (2*W)'(pp_hl_s2)) << H)
				+ (2*W)'(pp_ll_s2);
			p_s4     <= neg_s3 ? -signed'(sum_s3) : signed'(sum_s3);
		end
	end

	assign p = p_s4;
endmodule

// ===== src/sci_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment circle intersect square root
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module sci_sqrt import sci_pkg::*; #(
	parameter int RW = 176
) (
	input  logic             clk,
	input  logic             en,
	input  logic [RW-1:0]    rad,
	output logic [RW/2-1:0]  root,
	output logic             exact
);
	localparam int QW = RW / 2;

	logic [QW+1:0] rem_s  [QW];
	logic [QW-1:0] root_s [QW];
	logic [RW-1:0] rad_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [QW+1:0] rem_in, cur, trial;
		logic [QW-1:0] root_in;
		logic [RW-1:0] rad_in;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end

		assign cur   = {rem_in[QW-1:0], rad_in[RW-1:RW-2]};
		assign trial = {root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? cur - trial : cur;
				root_s[k] <= {root_in[QW-2:0], ge};
				rad_s[k]  <= rad_in << 2;
			end
		end
	end

	assign root  = root_s[QW-1];
	assign exact = rem_s[QW-1] == '0;
endmodule

// ===== src/sci_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment circle intersect checker
// Port-level properties of the result stream and the stall behavior.
// ----------------------------------------------------------------------------
module sci_checker import sci_pkg::*; #(
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 seg_ready,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic                 res_hit,
	input logic [T_FRAC_BITS:0] res_hit_time
);
	// A waiting result stalls the whole pipeline, input side included.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !seg_ready)
		else $error("input accepted while a result beat is stalled");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_hit) && $stable(res_hit_time))
		else $error("stalled result beat changed");

	a_miss_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_hit |-> res_hit_time == '0)
		else $error("miss carries a nonzero hit time");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_hit_time <= {1'b1, {T_FRAC_BITS{1'b0}}})
		else $error("hit time above one");
endmodule

bind segment_circle_intersect sci_checker #(.T_FRAC_BITS(T_FRAC_BITS)) u_sci_checker (
	.clk(clk),
	.arst_n(arst_n),
	.seg_ready(seg.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_hit(res.hit),
	.res_hit_time(res.hit_time)
);
